>>> rtl/mecanum_wheel_mixer_assert.svh
// Assertion macros for the mecanum wheel mixer top level.
`ifndef MECANUM_WHEEL_MIXER_ASSERT_SVH
`define MECANUM_WHEEL_MIXER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mecanum mixer check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mecanum mixer check failed");

`endif

>>> rtl/mwm_pkg.sv
// Shared constants and types for the mecanum wheel mixer.
package mwm_pkg;

  localparam int POWER_W   = 9;
  localparam int HEAD_W    = 11;
  localparam int SIGN_W    = 2;
  localparam int SHARE_W   = 7;
  localparam int NEUTRAL_W = 11;
  localparam int PULSE_W   = 12;
  // The wheel value never exceeds the saturated power, so it fits the power width.
  localparam int QUOT_W    = POWER_W;
  localparam int WHEELS    = 4;

  localparam logic [NEUTRAL_W-1:0] NEUTRAL_RESET = 11'd1500;
  localparam logic [SHARE_W-1:0]   SHARE_MAX     = 7'd100;

  localparam int FULL_TURN   = 360;
  localparam int QUARTER     = 90;
  localparam int HEAD_OFFSET = 3 * FULL_TURN;

  // Rotation sign codes as they arrive on the port.
  localparam logic [SIGN_W-1:0] SGN_ZERO    = 2'b00;
  localparam logic [SIGN_W-1:0] SGN_POS     = 2'b01;
  localparam logic [SIGN_W-1:0] SGN_NEG_ALT = 2'b10;
  localparam logic [SIGN_W-1:0] SGN_NEG     = 2'b11;

  // Wheel order inside the datapath.
  localparam int WHL_LF = 0;
  localparam int WHL_LR = 1;
  localparam int WHL_RF = 2;
  localparam int WHL_RR = 3;

  localparam int CMD_LAT  = 2;
  localparam int COMP_LAT = 3;
  localparam int DIV_LAT  = QUOT_W + 1;
  localparam int OUT_LAT  = 1;
  localparam int PIPE_LAT = CMD_LAT + COMP_LAT + DIV_LAT + OUT_LAT;

  typedef struct packed {
    logic vld;
    logic zero;
  } beat_ctl_t;

endpackage

>>> rtl/mecanum_wheel_mixer.sv
// Top level of the mecanum wheel mixer: drive command in, four wheel pulse widths out.
//
//   Channel   Handshake              Beat contents
//   -------   --------------------   ------------------------------------------------
//   input     start / busy           drive power, heading, rotation sign, rot. share
//   result    out_valid (strobe)     left front, left rear, right front, right rear
//   config    cfg_we                 neutral pulse width in microseconds
//
// The block is a fixed pipeline of 16 register stages and takes one command beat
// in every cycle; busy is never raised. Each result is shown for exactly one cycle.
// The depth comes from the 9-stage restoring divider (one quotient bit per stage)
// plus the decode, table lookup, product stages and the output register. rst_n is
// synchronous and active low; it clears the valid bits of every stage and restores
// the neutral pulse to 1500.
`include "mecanum_wheel_mixer_assert.svh"

module mecanum_wheel_mixer #(
  parameter int TRIG_FRAC_BITS = 15,
  parameter int MAX_POWER      = 500
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [mwm_pkg::POWER_W-1:0]         in_drive_power,
  input  logic signed [mwm_pkg::HEAD_W-1:0]   in_heading_deg,
  input  logic signed [mwm_pkg::SIGN_W-1:0]   in_rot_sign,
  input  logic [mwm_pkg::SHARE_W-1:0]         in_rot_share_pct,
  input  logic                                cfg_we,
  input  logic [mwm_pkg::NEUTRAL_W-1:0]       cfg_wdata,
  output logic                                out_valid,
  output logic [mwm_pkg::PULSE_W-1:0]         out_lf_pulse,
  output logic [mwm_pkg::PULSE_W-1:0]         out_lr_pulse,
  output logic [mwm_pkg::PULSE_W-1:0]         out_rf_pulse,
  output logic [mwm_pkg::PULSE_W-1:0]         out_rr_pulse
);
  import mwm_pkg::*;

  localparam int F     = TRIG_FRAC_BITS;
  localparam int TW    = F + 2;
  localparam int NW    = F + 18;
  localparam int NUMW  = NW + 1;
  // Wheel values run from minus to plus the largest power, one sign bit on top.
  localparam int WV_W  = QUOT_W + 1;
  // Neutral plus or minus a wheel value always fits one bit above the pulse width.
  localparam int SUM_W = PULSE_W + 1;
  localparam logic signed [SUM_W-1:0] PULSE_TOP = SUM_W'({PULSE_W{1'b1}});

  // The pipeline never stalls, so a command is taken whenever start is high.
  logic in_vld;

  assign busy   = 1'b0;
  assign in_vld = start & ~busy;

  // Neutral pulse register. The user is to rewrite it only while no command is in flight,
  // so that the output stage can read it directly; the block itself does not enforce this.
  logic [NEUTRAL_W-1:0] neutral_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_r <= NEUTRAL_RESET;
    end else if (cfg_we) begin
      neutral_r <= cfg_wdata;
    end
  end

  // Decode and trig lookup: two stages.
  logic                   cmd_vld;
  logic [POWER_W-1:0]     cmd_power;
  logic [SHARE_W-1:0]     cmd_share;
  logic [SHARE_W-1:0]     cmd_rest;
  logic [SIGN_W-1:0]      cmd_sign;
  logic signed [TW-1:0]   cmd_cos;
  logic signed [TW-1:0]   cmd_sin;

  mwm_cmd #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .MAX_POWER      (MAX_POWER)
  ) u_cmd (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (in_vld),
    .in_power   (in_drive_power),
    .in_heading (in_heading_deg),
    .in_sign    (in_rot_sign),
    .in_share   (in_rot_share_pct),
    .o_vld      (cmd_vld),
    .o_power    (cmd_power),
    .o_share    (cmd_share),
    .o_rest     (cmd_rest),
    .o_sign     (cmd_sign),
    .o_cos      (cmd_cos),
    .o_sin      (cmd_sin)
  );

  // Component products, magnitude sum and numerators: three stages.
  beat_ctl_t               comp_ctl;
  logic [POWER_W-1:0]      comp_power;
  logic [NW-1:0]           comp_norm;
  logic signed [NUMW-1:0]  comp_num [WHEELS];

  mwm_comp #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_comp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (cmd_vld),
    .in_power (cmd_power),
    .in_share (cmd_share),
    .in_rest  (cmd_rest),
    .in_sign  (cmd_sign),
    .in_cos   (cmd_cos),
    .in_sin   (cmd_sin),
    .o_ctl    (comp_ctl),
    .o_power  (comp_power),
    .o_norm   (comp_norm),
    .o_num    (comp_num)
  );

  // Dividend product and the divider steps: ten stages.
  beat_ctl_t           div_ctl;
  logic [QUOT_W-1:0]   div_quot [WHEELS];
  logic                div_neg [WHEELS];

  mwm_div #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (comp_ctl),
    .in_power (comp_power),
    .in_norm  (comp_norm),
    .in_num   (comp_num),
    .o_ctl    (div_ctl),
    .o_quot   (div_quot),
    .o_neg    (div_neg)
  );

  // Output stage. The quotient magnitude gets the numerator's sign back, which
  // gives truncation toward zero. When every drive component is zero the divider
  // result is meaningless and the wheel value is forced to zero. Left wheels add
  // their value to the neutral pulse and right wheels subtract it; the sum is then
  // clamped to the pulse range, which matters only for a neutral below its range.
  function automatic logic [PULSE_W-1:0] clamp_pulse(input logic signed [SUM_W-1:0] v);
    logic [PULSE_W-1:0] res;
    priority if (v < 0) begin
      res = '0;
    end else if (v > PULSE_TOP) begin
      res = '1;
    end else begin
      res = v[PULSE_W-1:0];
    end
    return res;
  endfunction

  logic signed [WV_W-1:0]   wval [WHEELS];
  logic signed [SUM_W-1:0]  neutral_s;

  assign neutral_s = signed'(SUM_W'(neutral_r));

  for (genvar w = 0; w < WHEELS; w++) begin : g_wval
    logic signed [WV_W-1:0] mag_s;

    assign mag_s   = signed'({1'b0, div_quot[w]});
    assign wval[w] = div_ctl.zero ? '0 : (div_neg[w] ? -mag_s : mag_s);
  end

  logic                 out_valid_r;
  logic [PULSE_W-1:0]   out_lf_r, out_lf_nxt;
  logic [PULSE_W-1:0]   out_lr_r, out_lr_nxt;
  logic [PULSE_W-1:0]   out_rf_r, out_rf_nxt;
  logic [PULSE_W-1:0]   out_rr_r, out_rr_nxt;

  always_comb begin
    out_lf_nxt = clamp_pulse(neutral_s + SUM_W'(wval[WHL_LF]));
    out_lr_nxt = clamp_pulse(neutral_s + SUM_W'(wval[WHL_LR]));
    out_rf_nxt = clamp_pulse(neutral_s - SUM_W'(wval[WHL_RF]));
    out_rr_nxt = clamp_pulse(neutral_s - SUM_W'(wval[WHL_RR]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_lf_r <= out_lf_nxt;
    out_lr_r <= out_lr_nxt;
    out_rf_r <= out_rf_nxt;
    out_rr_r <= out_rr_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_lf_pulse = out_lf_r;
  assign out_lr_pulse = out_lr_r;
  assign out_rf_pulse = out_rf_r;
  assign out_rr_pulse = out_rr_r;

  // Helpers for the checks below.
  logic                zero_beat;
  logic [PULSE_W-1:0]  neu_pulse;

  assign zero_beat = div_ctl.vld & div_ctl.zero;
  assign neu_pulse = {1'b0, neutral_r};

  // Every result strobe traces back to a command taken exactly one pipeline depth
  // earlier; a lost or duplicated valid bit in any stage breaks this.
  `MWM_ASSERT_IMP(a_strobe_latency, out_valid, $past(start && !busy, PIPE_LAT))

  // A command with no drive component leaves every wheel at the neutral pulse (checked on LF and RR).
  `MWM_ASSERT_NXT(a_zero_neutral, zero_beat, out_valid && ({out_lf_pulse, out_rr_pulse} == {2{$past(neu_pulse)}}))

endmodule

>>> rtl/mwm_cmd.sv
// Command decode and heading lookup: saturation, angle reduction, cos and sin.
module mwm_cmd #(
  parameter int TRIG_FRAC_BITS = 15,
  parameter int MAX_POWER      = 500
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic [mwm_pkg::POWER_W-1:0]         in_power,
  input  logic signed [mwm_pkg::HEAD_W-1:0]   in_heading,
  input  logic [mwm_pkg::SIGN_W-1:0]          in_sign,
  input  logic [mwm_pkg::SHARE_W-1:0]         in_share,
  output logic                                o_vld,
  output logic [mwm_pkg::POWER_W-1:0]         o_power,
  output logic [mwm_pkg::SHARE_W-1:0]         o_share,
  output logic [mwm_pkg::SHARE_W-1:0]         o_rest,
  output logic [mwm_pkg::SIGN_W-1:0]          o_sign,
  output logic signed [TRIG_FRAC_BITS+1:0]    o_cos,
  output logic signed [TRIG_FRAC_BITS+1:0]    o_sin
);
  import mwm_pkg::*;

  localparam int F      = TRIG_FRAC_BITS;
  localparam int TAB_W  = F + 1;
  localparam int TW     = F + 2;
  localparam int HPOS_W = 12;
  localparam int HSUM_W = HPOS_W + 1;
  localparam int DEG_W  = 9;
  localparam int ANG_W  = 7;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [POWER_W-1:0] POWER_SAT =
    (MAX_POWER >= (1 << POWER_W)) ? {POWER_W{1'b1}} : POWER_W'(MAX_POWER);
  localparam logic signed [HSUM_W-1:0] HOFS = HSUM_W'(HEAD_OFFSET);
  localparam logic [ANG_W-1:0] QTR = ANG_W'(QUARTER);

  typedef logic [TAB_W-1:0] sin_tab_t [0:QUARTER];

  // First-quadrant sine table, built at elaboration from a Q30 Taylor series.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t            tab;
    logic [63:0]         x;
    logic [63:0]         x2;
    logic [63:0]         term;
    logic signed [63:0]  sum;
    logic signed [63:0]  v;
    for (int a = 0; a <= QUARTER; a++) begin
      x    = (64'(a) * PI_Q30) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + (64'sd1 <<< (29 - F))) >>> (30 - F);
      if (v > (64'sd1 <<< F)) begin
        v = 64'sd1 <<< F;
      end
      tab[a] = TAB_W'(v);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // Stage 1: saturation, sign decode and reduction of the heading into 0..359.
  logic                       s1_vld_r;
  logic [POWER_W-1:0]         s1_power_r, s1_power_nxt;
  logic [SHARE_W-1:0]         s1_share_r, s1_share_nxt;
  logic [SHARE_W-1:0]         s1_rest_r,  s1_rest_nxt;
  logic [SIGN_W-1:0]          s1_sign_r,  s1_sign_nxt;
  logic [DEG_W-1:0]           s1_deg_r,   s1_deg_nxt;
  logic signed [HSUM_W-1:0]   hsum;
  logic [HPOS_W-1:0]          hpos;

  assign hsum = HSUM_W'(in_heading) + HOFS;
  assign hpos = hsum[HPOS_W-1:0];

  always_comb begin
    s1_power_nxt = (in_power > POWER_SAT) ? POWER_SAT : in_power;
    s1_share_nxt = (in_share > SHARE_MAX) ? SHARE_MAX : in_share;
    s1_rest_nxt  = SHARE_MAX - s1_share_nxt;
    unique case (in_sign)
      SGN_ZERO:             s1_sign_nxt = SGN_ZERO;
      SGN_POS:              s1_sign_nxt = SGN_POS;
      SGN_NEG, SGN_NEG_ALT: s1_sign_nxt = SGN_NEG;
    endcase
    priority if (hpos >= HPOS_W'(5 * FULL_TURN)) begin
      s1_deg_nxt = DEG_W'(hpos - HPOS_W'(5 * FULL_TURN));
    end else if (hpos >= HPOS_W'(4 * FULL_TURN)) begin
      s1_deg_nxt = DEG_W'(hpos - HPOS_W'(4 * FULL_TURN));
    end else if (hpos >= HPOS_W'(3 * FULL_TURN)) begin
      s1_deg_nxt = DEG_W'(hpos - HPOS_W'(3 * FULL_TURN));
    end else if (hpos >= HPOS_W'(2 * FULL_TURN)) begin
      s1_deg_nxt = DEG_W'(hpos - HPOS_W'(2 * FULL_TURN));
    end else if (hpos >= HPOS_W'(FULL_TURN)) begin
      s1_deg_nxt = DEG_W'(hpos - HPOS_W'(FULL_TURN));
    end else begin
      s1_deg_nxt = DEG_W'(hpos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_power_r <= s1_power_nxt;
    s1_share_r <= s1_share_nxt;
    s1_rest_r  <= s1_rest_nxt;
    s1_sign_r  <= s1_sign_nxt;
    s1_deg_r   <= s1_deg_nxt;
  end

  // Stage 2: quadrant split, table lookup and quadrant symmetry.
  logic                  s2_vld_r;
  logic [POWER_W-1:0]    s2_power_r;
  logic [SHARE_W-1:0]    s2_share_r;
  logic [SHARE_W-1:0]    s2_rest_r;
  logic [SIGN_W-1:0]     s2_sign_r;
  logic signed [TW-1:0]  s2_cos_r, s2_cos_nxt;
  logic signed [TW-1:0]  s2_sin_r, s2_sin_nxt;
  logic [1:0]            quad;
  logic [ANG_W-1:0]      ang;
  logic signed [TW-1:0]  sa;
  logic signed [TW-1:0]  ca;

  always_comb begin
    priority if (s1_deg_r >= DEG_W'(3 * QUARTER)) begin
      quad = 2'd3;
      ang  = ANG_W'(s1_deg_r - DEG_W'(3 * QUARTER));
    end else if (s1_deg_r >= DEG_W'(2 * QUARTER)) begin
      quad = 2'd2;
      ang  = ANG_W'(s1_deg_r - DEG_W'(2 * QUARTER));
    end else if (s1_deg_r >= DEG_W'(QUARTER)) begin
      quad = 2'd1;
      ang  = ANG_W'(s1_deg_r - DEG_W'(QUARTER));
    end else begin
      quad = 2'd0;
      ang  = ANG_W'(s1_deg_r);
    end
    sa = signed'({1'b0, SIN_TAB[ang]});
    ca = signed'({1'b0, SIN_TAB[QTR - ang]});
    unique case (quad)
      2'd0: begin
        s2_sin_nxt = sa;
        s2_cos_nxt = ca;
      end
      2'd1: begin
        s2_sin_nxt = ca;
        s2_cos_nxt = -sa;
      end
      2'd2: begin
        s2_sin_nxt = -sa;
        s2_cos_nxt = -ca;
      end
      2'd3: begin
        s2_sin_nxt = -ca;
        s2_cos_nxt = sa;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_power_r <= s1_power_r;
    s2_share_r <= s1_share_r;
    s2_rest_r  <= s1_rest_r;
    s2_sign_r  <= s1_sign_r;
    s2_cos_r   <= s2_cos_nxt;
    s2_sin_r   <= s2_sin_nxt;
  end

  assign o_vld   = s2_vld_r;
  assign o_power = s2_power_r;
  assign o_share = s2_share_r;
  assign o_rest  = s2_rest_r;
  assign o_sign  = s2_sign_r;
  assign o_cos   = s2_cos_r;
  assign o_sin   = s2_sin_r;

endmodule

>>> rtl/mwm_comp.sv
// Drive components, their magnitude sum and the four wheel numerators.
module mwm_comp #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic [mwm_pkg::POWER_W-1:0]        in_power,
  input  logic [mwm_pkg::SHARE_W-1:0]        in_share,
  input  logic [mwm_pkg::SHARE_W-1:0]        in_rest,
  input  logic [mwm_pkg::SIGN_W-1:0]         in_sign,
  input  logic signed [TRIG_FRAC_BITS+1:0]   in_cos,
  input  logic signed [TRIG_FRAC_BITS+1:0]   in_sin,
  output mwm_pkg::beat_ctl_t                 o_ctl,
  output logic [mwm_pkg::POWER_W-1:0]        o_power,
  output logic [TRIG_FRAC_BITS+17:0]         o_norm,
  output logic signed [TRIG_FRAC_BITS+18:0]  o_num [mwm_pkg::WHEELS]
);
  import mwm_pkg::*;

  localparam int F    = TRIG_FRAC_BITS;
  localparam int PCW  = F + 10;
  localparam int PRW  = POWER_W + SHARE_W;
  localparam int CW   = F + 17;
  localparam int NW   = F + 18;
  localparam int NUMW = NW + 1;

  // Stage 3: power times cos, sin and share.
  logic                   s3_vld_r;
  logic [POWER_W-1:0]     s3_power_r;
  logic [SHARE_W-1:0]     s3_rest_r;
  logic [SIGN_W-1:0]      s3_sign_r;
  logic signed [PCW-1:0]  s3_pc_r, s3_pc_nxt;
  logic signed [PCW-1:0]  s3_ps_r, s3_ps_nxt;
  logic [PRW-1:0]         s3_pr_r, s3_pr_nxt;
  logic signed [PCW-1:0]  pwr_s;

  assign pwr_s     = PCW'(signed'({1'b0, in_power}));
  assign s3_pc_nxt = pwr_s * PCW'(in_cos);
  assign s3_ps_nxt = pwr_s * PCW'(in_sin);
  assign s3_pr_nxt = PRW'(in_power) * PRW'(in_share);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_power_r <= in_power;
    s3_rest_r  <= in_rest;
    s3_sign_r  <= in_sign;
    s3_pc_r    <= s3_pc_nxt;
    s3_ps_r    <= s3_ps_nxt;
    s3_pr_r    <= s3_pr_nxt;
  end

  // Stage 4: forward, strafe and rotate components in units of 2^-F.
  logic                   s4_vld_r;
  logic [POWER_W-1:0]     s4_power_r;
  logic signed [CW-1:0]   s4_f_r, s4_f_nxt;
  logic signed [CW-1:0]   s4_s_r, s4_s_nxt;
  logic signed [CW-1:0]   s4_t_r, s4_t_nxt;
  logic signed [CW-1:0]   rest_s;
  logic [CW-1:0]          tmag;

  assign rest_s   = CW'(signed'({1'b0, s3_rest_r}));
  assign s4_f_nxt = CW'(s3_pc_r) * rest_s;
  assign s4_s_nxt = CW'(s3_ps_r) * rest_s;
  assign tmag     = CW'(s3_pr_r) << F;

  always_comb begin
    unique case (s3_sign_r)
      SGN_POS: s4_t_nxt = signed'(tmag);
      SGN_NEG: s4_t_nxt = -signed'(tmag);
      default: s4_t_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_power_r <= s3_power_r;
    s4_f_r     <= s4_f_nxt;
    s4_s_r     <= s4_s_nxt;
    s4_t_r     <= s4_t_nxt;
  end

  // Stage 5: magnitude sum and wheel numerators.
  beat_ctl_t               s5_ctl_r, s5_ctl_nxt;
  logic [POWER_W-1:0]      s5_power_r;
  logic [NW-1:0]           s5_norm_r, s5_norm_nxt;
  logic signed [NUMW-1:0]  s5_num_r [WHEELS];
  logic signed [NUMW-1:0]  s5_num_nxt [WHEELS];
  logic [NW-1:0]           fm, sm, tm;
  logic signed [NUMW-1:0]  fe, se, te;

  always_comb begin
    fm = NW'(s4_f_r[CW-1] ? -s4_f_r : s4_f_r);
    sm = NW'(s4_s_r[CW-1] ? -s4_s_r : s4_s_r);
    tm = NW'(s4_t_r[CW-1] ? -s4_t_r : s4_t_r);
    s5_norm_nxt = fm + sm + tm;
    fe = NUMW'(s4_f_r);
    se = NUMW'(s4_s_r);
    te = NUMW'(s4_t_r);
    s5_num_nxt[WHL_LF] = fe + se - te;
    s5_num_nxt[WHL_LR] = fe - se - te;
    s5_num_nxt[WHL_RF] = fe - se + te;
    s5_num_nxt[WHL_RR] = fe + se + te;
    s5_ctl_nxt.vld  = s4_vld_r;
    s5_ctl_nxt.zero = (s5_norm_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_ctl_r <= '0;
    end else begin
      s5_ctl_r <= s5_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s5_power_r <= s4_power_r;
    s5_norm_r  <= s5_norm_nxt;
    s5_num_r   <= s5_num_nxt;
  end

  assign o_ctl   = s5_ctl_r;
  assign o_power = s5_power_r;
  assign o_norm  = s5_norm_r;
  assign o_num   = s5_num_r;

endmodule

>>> rtl/mwm_div.sv
// Four-lane pipelined restoring divider: wheel value = power * |num| / norm.
module mwm_div #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mwm_pkg::beat_ctl_t                 in_ctl,
  input  logic [mwm_pkg::POWER_W-1:0]        in_power,
  input  logic [TRIG_FRAC_BITS+17:0]         in_norm,
  input  logic signed [TRIG_FRAC_BITS+18:0]  in_num [mwm_pkg::WHEELS],
  output mwm_pkg::beat_ctl_t                 o_ctl,
  output logic [mwm_pkg::QUOT_W-1:0]         o_quot [mwm_pkg::WHEELS],
  output logic                               o_neg [mwm_pkg::WHEELS]
);
  import mwm_pkg::*;

  localparam int F    = TRIG_FRAC_BITS;
  localparam int NW   = F + 18;
  localparam int NUMW = NW + 1;
  // The dividend is below norm * 2^QUOT_W, so this width holds every partial remainder.
  localparam int RW   = NW + QUOT_W;

  // Stage outputs, indexed by step; step 0 is the dividend product.
  beat_ctl_t           ctl_s [QUOT_W+1];
  logic [NW-1:0]       den_s [QUOT_W+1];
  logic [RW-1:0]       rem_s [QUOT_W+1][WHEELS];
  logic [QUOT_W-1:0]   quo_s [QUOT_W+1][WHEELS];
  logic                neg_s [QUOT_W+1][WHEELS];

  beat_ctl_t       a_ctl_r;
  logic [NW-1:0]   a_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
    end else begin
      a_ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    a_den_r <= in_norm;
  end

  assign ctl_s[0] = a_ctl_r;
  assign den_s[0] = a_den_r;

  for (genvar w = 0; w < WHEELS; w++) begin : g_prod
    logic [NW-1:0]  mag;
    logic [RW-1:0]  a_rem_r, a_rem_nxt;
    logic           a_neg_r;

    assign mag       = NW'(in_num[w][NUMW-1] ? -in_num[w] : in_num[w]);
    assign a_rem_nxt = RW'(in_power) * RW'(mag);

    always_ff @(posedge clk) begin
      a_rem_r <= a_rem_nxt;
      a_neg_r <= in_num[w][NUMW-1];
    end

    assign rem_s[0][w] = a_rem_r;
    assign quo_s[0][w] = '0;
    assign neg_s[0][w] = a_neg_r;
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < QUOT_W; j++) begin : g_step
    localparam int B = QUOT_W - 1 - j;
    logic [RW-1:0]  dsh;
    beat_ctl_t      ctl_r;
    logic [NW-1:0]  den_r;

    assign dsh = RW'(den_s[j]) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r <= '0;
      end else begin
        ctl_r <= ctl_s[j];
      end
    end

    always_ff @(posedge clk) begin
      den_r <= den_s[j];
    end

    assign ctl_s[j+1] = ctl_r;
    assign den_s[j+1] = den_r;

    for (genvar w = 0; w < WHEELS; w++) begin : g_lane
      logic               take;
      logic [RW-1:0]      rem_r, rem_nxt;
      logic [QUOT_W-1:0]  quo_r, quo_nxt;
      logic               neg_r;

      assign take    = (rem_s[j][w] >= dsh);
      assign rem_nxt = take ? (rem_s[j][w] - dsh) : rem_s[j][w];
      assign quo_nxt = quo_s[j][w] | (QUOT_W'(take) << B);

      always_ff @(posedge clk) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        neg_r <= neg_s[j][w];
      end

      assign rem_s[j+1][w] = rem_r;
      assign quo_s[j+1][w] = quo_r;
      assign neg_s[j+1][w] = neg_r;
    end
  end

  assign o_ctl = ctl_s[QUOT_W];

  for (genvar w = 0; w < WHEELS; w++) begin : g_out
    assign o_quot[w] = quo_s[QUOT_W][w];
    assign o_neg[w]  = neg_s[QUOT_W][w];
  end

endmodule
